// ----- sv/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpe_pkg
// Types and constants shared by the button debounce / press event core.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int unsigned NUM_BUTTONS = 2;
  localparam int unsigned MAX_EVENTS  = 4;
  localparam int unsigned EV_IDX_W    = 2;
  localparam int unsigned EV_CNT_W    = 3;
  localparam int unsigned NUM_CODES   = 5;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned TIME_W      = 32;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd150;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_CLICK    = 3'd1,
    EV_RELEASED = 3'd2,
    EV_LONG     = 3'd3,
    EV_REPEAT   = 3'd4
  } bpe_event_e;

  typedef struct packed {
    logic                   req_type;
    logic [TIME_W-1:0]      now_ms;
    logic [NUM_BUTTONS-1:0] raw_pressed;
  } bpe_in_t;

  typedef struct packed {
    logic                   button_index;
    logic [2:0]             event_code;
    logic [NUM_BUTTONS-1:0] pressed_mask;
    logic                   last;
  } bpe_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] repeat_interval;
  } bpe_cfg_t;

  typedef struct packed {
    logic       btn;
    bpe_event_e code;
  } bpe_ev_t;

  // one queue entry: all events of one update request
  typedef struct packed {
    logic [EV_IDX_W-1:0]        last_idx;
    bpe_ev_t [MAX_EVENTS-1:0]   ev;
    logic [NUM_BUTTONS-1:0]     mask;
  } bpe_batch_t;

endpackage

// ----- sv/bpe_front.sv -----
// ----------------------------------------------------------------------------
// bpe_front
// Accepts requests, updates per-button debounce state and builds the event
// list of each update as one batch for the queue.
// ----------------------------------------------------------------------------
module bpe_front import bpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bpe_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  bpe_in_t    in_data_i,
  input  logic       full_i,
  output logic       push_o,
  output bpe_batch_t batch_o
);

  logic [NUM_BUTTONS-1:0] cand_lvl_q, cand_lvl_d;
  logic [NUM_BUTTONS-1:0] stable_q, stable_d;
  logic [NUM_BUTTONS-1:0] long_fired_q, long_fired_d;
  logic [TIME_W-1:0]      cand_since_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      cand_since_d [NUM_BUTTONS];
  logic [TIME_W-1:0]      press_start_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      press_start_d [NUM_BUTTONS];
  logic [TIME_W-1:0]      last_ev_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      last_ev_d [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] stab_n, rise, fall, fire_long, fire_rep;
  logic [NUM_CODES-1:0]   fires [NUM_BUTTONS];
  logic [CFG_W-1:0]       lp_eff, rp_eff;
  logic                   accept, upd, clr;
  logic [EV_CNT_W-1:0]    ev_cnt;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign upd        = accept && (in_data_i.req_type == REQ_UPDATE);
  assign clr        = accept && (in_data_i.req_type == REQ_CLEAR);
  assign lp_eff     = (cfg_i.long_press_time == '0) ? CFG_W'(1) : cfg_i.long_press_time;
  assign rp_eff     = (cfg_i.repeat_interval == '0) ? CFG_W'(1) : cfg_i.repeat_interval;

  // per-button classification, all time deltas against the old state
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (in_data_i.raw_pressed[i] != cand_lvl_q[i]) begin
        stab_n[i] = stable_q[i];
      end else if ((in_data_i.now_ms - cand_since_q[i]) >= TIME_W'(cfg_i.debounce_time)) begin
        stab_n[i] = in_data_i.raw_pressed[i];
      end else begin
        stab_n[i] = stable_q[i];
      end
      rise[i]      = stab_n[i] && !stable_q[i];
      fall[i]      = !stab_n[i] && stable_q[i];
      fire_long[i] = stab_n[i] && stable_q[i] && !long_fired_q[i]
                     && ((in_data_i.now_ms - press_start_q[i]) >= TIME_W'(lp_eff));
      fire_rep[i]  = stab_n[i] && stable_q[i] && long_fired_q[i]
                     && ((in_data_i.now_ms - last_ev_q[i]) >= TIME_W'(rp_eff));
      // bit k fires event code k
      fires[i] = {fire_rep[i], fire_long[i], fall[i], fall[i] && !long_fired_q[i], rise[i]};
    end
  end

  always_comb begin
    logic [EV_CNT_W-1:0] pos;
    pos     = '0;
    batch_o = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        if (fires[i][k] && (pos < EV_CNT_W'(MAX_EVENTS))) begin
          batch_o.ev[pos[EV_IDX_W-1:0]].btn  = 1'(i);
          batch_o.ev[pos[EV_IDX_W-1:0]].code = bpe_event_e'(3'(k));
          pos = pos + EV_CNT_W'(1);
        end
      end
    end
    ev_cnt           = pos;
    batch_o.last_idx = EV_IDX_W'(pos - EV_CNT_W'(1));
    batch_o.mask     = stab_n;
  end

  assign push_o = upd && (ev_cnt != '0);

  always_comb begin
    cand_lvl_d   = cand_lvl_q;
    stable_d     = stable_q;
    long_fired_d = long_fired_q;
    cand_since_d  = cand_since_q;
    press_start_d = press_start_q;
    last_ev_d     = last_ev_q;
    if (clr) begin
      long_fired_d = '1;
    end else if (upd) begin
      cand_lvl_d = in_data_i.raw_pressed;
      stable_d   = stab_n;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (in_data_i.raw_pressed[i] != cand_lvl_q[i]) begin
          cand_since_d[i] = in_data_i.now_ms;
        end
        if (rise[i]) begin
          press_start_d[i] = in_data_i.now_ms;
          last_ev_d[i]     = in_data_i.now_ms;
          long_fired_d[i]  = 1'b0;
        end
        if (fire_long[i]) begin
          long_fired_d[i] = 1'b1;
          last_ev_d[i]    = in_data_i.now_ms;
        end
        if (fire_rep[i]) begin
          last_ev_d[i] = in_data_i.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_lvl_q   <= '0;
      stable_q     <= '0;
      long_fired_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cand_since_q[i]  <= '0;
        press_start_q[i] <= '0;
        last_ev_q[i]     <= '0;
      end
    end else begin
      cand_lvl_q    <= cand_lvl_d;
      stable_q      <= stable_d;
      long_fired_q  <= long_fired_d;
      cand_since_q  <= cand_since_d;
      press_start_q <= press_start_d;
      last_ev_q     <= last_ev_d;
    end
  end

  a_stable_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(stable_q))
    else $error("debounced state changed without an update");

  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> !push_o)
    else $error("clear request produced events");

endmodule

// ----- sv/bpe_fifo.sv -----
// ----------------------------------------------------------------------------
// bpe_fifo
// Short queue of event batches between the front and the back part.
// ----------------------------------------------------------------------------
module bpe_fifo import bpe_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bpe_batch_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output bpe_batch_t data_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bpe_batch_t         mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ----- sv/bpe_back.sv -----
// ----------------------------------------------------------------------------
// bpe_back
// Walks the head batch one event per unstalled cycle to the output register.
// ----------------------------------------------------------------------------
module bpe_back import bpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bpe_batch_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output bpe_out_t   out_data_o
);

  logic [EV_IDX_W-1:0] sub_q, sub_d;
  logic                out_valid_q, out_valid_d;
  bpe_out_t            out_data_q, out_data_d;
  bpe_ev_t             sel;
  logic                load, is_last;

  always_comb begin
    sel         = head_i.ev[sub_q];
    load        = !empty_i && (!out_valid_q || !out_stall_i);
    is_last     = (sub_q == head_i.last_idx);
    pop_o       = load && is_last;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d             = 1'b1;
      out_data_d.button_index = sel.btn;
      out_data_d.event_code   = sel.code;
      out_data_d.pressed_mask = head_i.mask;
      out_data_d.last         = is_last;
      sub_d = is_last ? '0 : sub_q + EV_IDX_W'(1);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (sub_q <= head_i.last_idx))
    else $error("event index beyond batch");

endmodule

// ----- sv/button_debounce_press_events_core.sv -----
// Flow: an accepted update is written into the batch queue, and its first event
// is then loaded from the head of the queue into the output register.
// Throughput: one request per cycle enters while the batch queue has room; events
// leave one per cycle while the output is not stalled; an update yields 0 to 4
// events. A four-entry batch queue decouples request intake from event delivery.
// Reset: all button state zero, timing registers to 50 / 2000 / 150 ms.
// ----------------------------------------------------------------------------
// button_debounce_press_events_core
// Debounce of two buttons with press, click, release, long-press and repeat
// events, plus the configuration registers.
// ----------------------------------------------------------------------------
module button_debounce_press_events_core import bpe_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bpe_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bpe_out_t             out_data_o
);

  bpe_cfg_t   cfg_q, cfg_d;
  logic       push, full, pop, empty;
  bpe_batch_t push_batch, head_batch;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_d.debounce_time   = cfg_wdata_i;
        CFG_LONG_PRESS: cfg_d.long_press_time = cfg_wdata_i;
        CFG_REPEAT:     cfg_d.repeat_interval = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DEBOUNCE_RST;
      cfg_q.long_press_time <= LONG_PRESS_RST;
      cfg_q.repeat_interval <= REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .batch_o    (push_batch)
  );

  bpe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_batch),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_batch),
    .empty_o (empty)
  );

  bpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_batch),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/button_debounce_press_events_core_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_events_core_tb
// Self-checking bench for the two-button debounce / press event core. A
// scoreboard predicts the event stream of every request, and each event
// delivered by the core is compared against it. Timing registers cycle
// through default, all-zero, all-ones and mixed settings, with random
// gaps on the request side and random stalls on the event side.
// ----------------------------------------------------------------------------
module button_debounce_press_events_core_tb import bpe_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 16;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bpe_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bpe_out_t             out_data;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  button_debounce_press_events_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // timing registers as the core should hold them
  logic [CFG_W-1:0] db_ms = DEBOUNCE_RST;
  logic [CFG_W-1:0] lp_ms = LONG_PRESS_RST;
  logic [CFG_W-1:0] rp_ms = REPEAT_RST;

  // per-button debounce and event state
  logic [NUM_BUTTONS-1:0] cand_lvl  = '0;
  logic [NUM_BUTTONS-1:0] debounced = '0;
  logic [NUM_BUTTONS-1:0] long_done = '0;
  logic [TIME_W-1:0]      cand_since [NUM_BUTTONS] = '{default: '0};
  logic [TIME_W-1:0]      press_t    [NUM_BUTTONS] = '{default: '0};
  logic [TIME_W-1:0]      last_ev_t  [NUM_BUTTONS] = '{default: '0};

  bpe_in_t  req_queue [$];
  bpe_out_t events_due [$];
  bpe_out_t want;

  int n_queued  = 0;
  int n_updates = 0;
  int n_clears  = 0;
  int n_events  = 0;
  int errors    = 0;
  int gap_left  = 0;
  int stall_left = 0;
  bit calm      = 1'b0;

  logic [TIME_W-1:0]      t_now = '0;
  logic [NUM_BUTTONS-1:0] hold  = '0;

  task automatic predict_events(input bpe_in_t req);
    bpe_ev_t           evs [$];
    logic [CFG_W-1:0]  lp;
    logic [CFG_W-1:0]  rp;
    logic [TIME_W-1:0] dt;
    logic              was;
    logic              lvl;
    bpe_out_t          r;
    int                b;
    int                k;
    lp = (lp_ms == '0) ? 16'd1 : lp_ms;
    rp = (rp_ms == '0) ? 16'd1 : rp_ms;
    if (req.req_type == REQ_CLEAR) begin
      long_done = '1;
      return;
    end
    for (b = 0; b < NUM_BUTTONS; b++) begin
      was = debounced[b];
      lvl = req.raw_pressed[b];
      dt  = req.now_ms - cand_since[b];
      if (lvl != cand_lvl[b]) begin
        cand_lvl[b]   = lvl;
        cand_since[b] = req.now_ms;
      end else if (dt >= db_ms) begin
        debounced[b] = lvl;
      end
      if (debounced[b] && !was) begin
        press_t[b]   = req.now_ms;
        long_done[b] = 1'b0;
        last_ev_t[b] = req.now_ms;
        evs.push_back('{1'(b), EV_PRESSED});
      end
      if (!debounced[b] && was) begin
        if (!long_done[b]) evs.push_back('{1'(b), EV_CLICK});
        evs.push_back('{1'(b), EV_RELEASED});
      end
      dt = req.now_ms - press_t[b];
      if (debounced[b] && !long_done[b] && dt >= lp) begin
        long_done[b] = 1'b1;
        last_ev_t[b] = req.now_ms;
        evs.push_back('{1'(b), EV_LONG});
      end
      dt = req.now_ms - last_ev_t[b];
      if (debounced[b] && long_done[b] && dt >= rp) begin
        last_ev_t[b] = req.now_ms;
        evs.push_back('{1'(b), EV_REPEAT});
      end
    end
    for (k = 0; k < evs.size(); k++) begin
      r.button_index = evs[k].btn;
      r.event_code   = evs[k].code;
      r.pressed_mask = debounced;
      r.last         = (k == evs.size() - 1);
      events_due.push_back(r);
    end
  endtask

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_events(in_data);
        if (in_data.req_type == REQ_CLEAR) n_clears++;
        else n_updates++;
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(99) < 3) calm = !calm;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= req_queue.pop_front();
          if (calm) gap_left = 0;
          else begin
            k_gap: begin
              int unsigned r;
              r = $urandom_range(99);
              gap_left = (r < 55) ? 0 : (r < 88) ? $urandom_range(3, 1) :
                         $urandom_range(40, 8);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_events++;
        if (events_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected event btn %0d code %0d mask %b last %b", $time,
                   out_data.button_index, out_data.event_code, out_data.pressed_mask,
                   out_data.last);
        end else begin
          want = events_due.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t: expected btn %0d code %0d mask %b last %b", $time,
                     want.button_index, want.event_code, want.pressed_mask, want.last);
            $display("%0t:   actual btn %0d code %0d mask %b last %b", $time,
                     out_data.button_index, out_data.event_code, out_data.pressed_mask,
                     out_data.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < 20) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) :
                     $urandom_range(3, 1);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no request or event moved for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  task automatic queue_update(input logic [NUM_BUTTONS-1:0] raw,
                              input logic [TIME_W-1:0] t);
    bpe_in_t req;
    req.req_type    = REQ_UPDATE;
    req.now_ms      = t;
    req.raw_pressed = raw;
    req_queue.push_back(req);
    n_queued++;
  endtask

  task automatic queue_clear();
    bpe_in_t req;
    req.req_type    = REQ_CLEAR;
    req.now_ms      = $urandom;
    req.raw_pressed = NUM_BUTTONS'($urandom);
    req_queue.push_back(req);
    n_queued++;
  endtask

  // mostly held presses with random timing, some bounce, clears and time jumps
  task automatic queue_random(input int n, input int unsigned step_max,
                              input int unsigned flip_pct);
    int                     k;
    int                     b;
    int unsigned            r;
    logic [NUM_BUTTONS-1:0] bounce;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        queue_clear();
      end else begin
        if (r < 12) t_now = t_now;
        else if (r < 15) t_now = t_now + $urandom;
        else t_now = t_now + $urandom_range(step_max, 1);
        for (b = 0; b < NUM_BUTTONS; b++)
          if ($urandom_range(99) < flip_pct) hold[b] = !hold[b];
        bounce = ($urandom_range(99) < 8) ? NUM_BUTTONS'($urandom_range(3, 1)) : '0;
        queue_update(hold ^ bounce, t_now);
      end
    end
  endtask

  task automatic wait_idle();
    while ((n_updates + n_clears) != n_queued || events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                            input logic [CFG_W-1:0] rp);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= db;
    @(posedge clk);
    cfg_idx   <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_idx   <= CFG_REPEAT;
    cfg_wdata <= rp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    db_ms = db;
    lp_ms = lp;
    rp_ms = rp;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: press, long press, repeat, release, click, clear, wrap
    queue_update(2'b00, 32'd0);
    queue_update(2'b11, 32'd10);
    queue_update(2'b11, 32'd60);
    queue_update(2'b11, 32'd2059);
    queue_update(2'b11, 32'd2060);
    queue_update(2'b11, 32'd2209);
    queue_update(2'b11, 32'd2210);
    queue_update(2'b01, 32'd2211);
    queue_update(2'b01, 32'd2261);
    queue_update(2'b00, 32'd2300);
    queue_update(2'b00, 32'd2350);
    queue_update(2'b10, 32'd2400);
    queue_update(2'b10, 32'd2450);
    queue_clear();
    queue_update(2'b00, 32'd2500);
    queue_update(2'b00, 32'd2550);
    queue_update(2'b01, 32'd2600);
    queue_update(2'b01, 32'd2650);
    queue_update(2'b10, 32'd2700);
    queue_update(2'b10, 32'd2750);
    queue_update(2'b01, 32'd2760);
    queue_update(2'b10, 32'd2770);
    queue_update(2'b10, 32'hFFFF_FFF0);
    queue_update(2'b00, 32'hFFFF_FFFF);
    queue_update(2'b00, 32'h0000_0031);
    t_now = 32'h0000_0031;
    wait_idle();

    set_timing(16'd0, 16'd0, 16'd0);
    queue_random(30, 3, 20);
    wait_idle();

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(30, 30000, 5);
    wait_idle();

    set_timing(16'd5, 16'd40, 16'd10);
    t_now = 32'hFFFF_FF80;
    queue_random(60, 12, 12);
    wait_idle();

    set_timing(CFG_W'($urandom_range(30)), CFG_W'($urandom_range(200, 20)),
               CFG_W'($urandom_range(40, 1)));
    queue_random(50, 25, 10);
    wait_idle();

    set_timing(16'd0, 16'd1, 16'hFFFF);
    queue_random(25, 5, 15);
    wait_idle();

    $display("Sent %0d updates and %0d clears, checked %0d events,", n_updates, n_clears,
             n_events);
    $display("over six timing settings including all-zero and all-ones registers.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- button_debounce_press_events_core.f -----
sv/bpe_pkg.sv
sv/bpe_front.sv
sv/bpe_fifo.sv
sv/bpe_back.sv
sv/button_debounce_press_events_core.sv
tb/button_debounce_press_events_core_tb.sv
